// ===== hw/rtl/per_atom_virial_accumulator_defines.svh =====
// ---------------------------------------------------------------------------
// per_atom_virial_accumulator_defines.svh
// Assertion macros used by the per-atom virial accumulator checker.
// ---------------------------------------------------------------------------
`ifndef PER_ATOM_VIRIAL_ACCUMULATOR_DEFINES_SVH
`define PER_ATOM_VIRIAL_ACCUMULATOR_DEFINES_SVH

// Clocked property with reset disable.
`define PVACC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold at a clock edge.
`define PVACC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/pvacc_pkg.sv =====
// ---------------------------------------------------------------------------
// pvacc_pkg
// Types, codes and helpers of the per-atom virial accumulator.
// ---------------------------------------------------------------------------
package pvacc_pkg;

  localparam int ATOM_W = 12;
  localparam int NCOMP  = 6;

  // Request codes
  localparam logic [2:0] REQ_TALLY4   = 3'd3;
  localparam logic [2:0] REQ_READ     = 3'd4;
  localparam logic [2:0] REQ_READ_CLR = 3'd5;

  // Result kinds
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Register index (paddr[2])
  localparam logic REG_SCALE = 1'b0;
  localparam logic REG_DIM   = 1'b1;

  localparam logic [1:0]  DIM_FULL    = 2'd3;
  localparam logic [31:0] SCALE_RESET = 32'h0001_0000;

  localparam logic [63:0] SIGN64   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAXPOS64 = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [ATOM_W-1:0] atom_a;
    logic [ATOM_W-1:0] atom_b;
    logic [ATOM_W-1:0] atom_c;
    logic [ATOM_W-1:0] atom_d;
    logic signed [31:0] sep_x;
    logic signed [31:0] sep_y;
    logic signed [31:0] sep_z;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic              batch_end;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    logic signed [63:0] sum_xx;
    logic signed [63:0] sum_yy;
    logic signed [63:0] sum_zz;
    logic signed [63:0] sum_xy;
    logic signed [63:0] sum_xz;
    logic signed [63:0] sum_yz;
  } out_item_t;

  typedef logic [NCOMP-1:0][63:0] row_t;

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (((a ^ s) & (b ^ s)) >> 63 != 64'd0) begin
      return a[63] ? SIGN64 : MAXPOS64;
    end
    return s;
  endfunction

endpackage

// ===== hw/rtl/pvacc_term.sv =====
// ---------------------------------------------------------------------------
// pvacc_term
// Three-stage pipeline: factor*a*b in Q16.16, rounded to saturated Q32.32.
// ---------------------------------------------------------------------------
module pvacc_term (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] factor_i,
  output logic [63:0] term_o
);

  logic [31:0] ma, mb, mf;
  logic [63:0] p_q, lo_q, hi_q, term_q;
  logic [31:0] mf_q;
  logic        neg1_q, neg2_q;
  logic [64:0] lo2;
  logic [63:0] r;
  logic        big;

  assign ma = a_i[31] ? (~a_i + 32'd1) : a_i;
  assign mb = b_i[31] ? (~b_i + 32'd1) : b_i;
  assign mf = factor_i[31] ? (~factor_i + 32'd1) : factor_i;

  // Stage 1: magnitude product of the two vector components
  always_ff @(posedge clk_i) begin
    p_q    <= 64'(ma) * 64'(mb);
    mf_q   <= mf;
    neg1_q <= a_i[31] ^ b_i[31] ^ factor_i[31];
  end

  // Stage 2: both halves times the factor
  always_ff @(posedge clk_i) begin
    lo_q   <= 64'(p_q[31:0]) * 64'(mf_q);
    hi_q   <= 64'(p_q[63:32]) * 64'(mf_q);
    neg2_q <= neg1_q;
  end

  // Stage 3: round half away from zero, then saturate
  always_comb begin
    lo2 = {1'b0, lo_q} + 65'h8000;
    big = |hi_q[63:47];
    r   = (hi_q << 16) + {16'd0, lo2[63:16]} + (64'(lo2[64]) << 48);
  end

  always_ff @(posedge clk_i) begin
    if (neg2_q) begin
      term_q <= (big || r > pvacc_pkg::SIGN64) ? pvacc_pkg::SIGN64 : (64'd0 - r);
    end else begin
      term_q <= (big || r > pvacc_pkg::MAXPOS64) ? pvacc_pkg::MAXPOS64 : r;
    end
  end

  assign term_o = term_q;

endmodule

// ===== hw/rtl/per_atom_virial_accumulator.sv =====
// ---------------------------------------------------------------------------
// per_atom_virial_accumulator
// Six Q32.32 virial sums per atom, kept in one 384-bit-wide row memory and
// updated by read-modify-write from factor*r*f tally items.
// ---------------------------------------------------------------------------
//
//   channel   | handshake             | payload
//   ----------+-----------------------+-------------------------
//   input     | in_valid_i/in_ready_o | in_data_i  (in_item_t)
//   result    | out_valid_o/out_ready_i | out_data_o (out_item_t)
//   config    | psel/penable/pwrite   | paddr, pwdata, prdata
//
// One item at a time. A tally waits in S_MUL for the product pipeline, then
// reads one row per atom through the single memory read port, with write
// back overlapped, does the last write back and leaves; only a tally with
// batch_end set loads a done result. A read or read-and-clear skips S_MUL
// and loads a read result after its single row access.
// After reset the memory is cleared one row a cycle, all Depth rows
// (min(MAX_ATOMS, 4096)), with in_ready_o low. A stalled result holds the
// sequencer in its result state until the output register frees.
module per_atom_virial_accumulator #(
  parameter int MAX_ATOMS = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pvacc_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pvacc_pkg::out_item_t out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int AtomSpan = 1 << pvacc_pkg::ATOM_W;
  localparam int Depth    = (MAX_ATOMS < AtomSpan) ? MAX_ATOMS : AtomSpan;
  localparam int AW       = $clog2(Depth);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_RMW    = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0] state_q, state_d;
  pvacc_pkg::in_item_t  item_q, item_d;
  pvacc_pkg::out_item_t out_q, out_d;
  logic        out_valid_q, out_valid_d;
  logic [1:0]  mul_cnt_q, mul_cnt_d;
  logic [2:0]  k_q, k_d;
  logic        wb_valid_q, wb_valid_d;
  logic [AW-1:0] wb_addr_q, wb_addr_d;
  logic        fwd_q, fwd_d;
  pvacc_pkg::row_t fwd_data_q, fwd_data_d;
  pvacc_pkg::row_t res_q, res_d;
  pvacc_pkg::row_t rdata_q;
  logic [AW-1:0] clr_q, clr_d;
  logic [31:0] scale_q;
  logic [1:0]  dim_q;

  pvacc_pkg::row_t mem [Depth];

  // ---- configuration port ----
  logic cfg_we;
  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= pvacc_pkg::SCALE_RESET;
      dim_q   <= pvacc_pkg::DIM_FULL;
    end else if (cfg_we) begin
      if (paddr[2] == pvacc_pkg::REG_SCALE) begin
        scale_q <= pwdata;
      end else begin
        dim_q <= pwdata[1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == pvacc_pkg::REG_SCALE) begin
      prdata = scale_q;
    end else begin
      prdata = {30'd0, dim_q};
    end
  end

  // ---- product lanes: xx, yy, zz, xy, xz, yz ----
  logic        full;
  logic [31:0] sz, fz;
  pvacc_pkg::row_t term;

  // Drop z inputs unless dim is DIM_FULL
  assign full = (dim_q == pvacc_pkg::DIM_FULL);
  assign sz   = full ? item_q.sep_z : 32'd0;
  assign fz   = full ? item_q.force_z : 32'd0;

  pvacc_term u_xx (.clk_i, .a_i(item_q.sep_x), .b_i(item_q.force_x), .factor_i(scale_q),
                   .term_o(term[5]));
  pvacc_term u_yy (.clk_i, .a_i(item_q.sep_y), .b_i(item_q.force_y), .factor_i(scale_q),
                   .term_o(term[4]));
  pvacc_term u_zz (.clk_i, .a_i(sz), .b_i(fz), .factor_i(scale_q),
                   .term_o(term[3]));
  pvacc_term u_xy (.clk_i, .a_i(item_q.sep_x), .b_i(item_q.force_y), .factor_i(scale_q),
                   .term_o(term[2]));
  pvacc_term u_xz (.clk_i, .a_i(item_q.sep_x), .b_i(fz), .factor_i(scale_q),
                   .term_o(term[1]));
  pvacc_term u_yz (.clk_i, .a_i(item_q.sep_y), .b_i(fz), .factor_i(scale_q),
                   .term_o(term[0]));

  // ---- sequencer ----
  logic        is_tally;
  logic [2:0]  n_atoms;
  logic [pvacc_pkg::ATOM_W-1:0] atom_sel;
  logic        atom_ok;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  pvacc_pkg::row_t mem_wdata, cur, upd;

  assign is_tally = (item_q.req_type <= pvacc_pkg::REQ_TALLY4);
  assign n_atoms  = is_tally ? ({1'b0, item_q.req_type[1:0]} + 3'd1) : 3'd1;

  always_comb begin
    unique case (k_q[1:0])
      2'd0:    atom_sel = item_q.atom_a;
      2'd1:    atom_sel = item_q.atom_b;
      2'd2:    atom_sel = item_q.atom_c;
      default: atom_sel = item_q.atom_d;
    endcase
  end

  assign atom_ok = (32'(atom_sel) < 32'(MAX_ATOMS));
  assign rd_addr = atom_sel[AW-1:0];

  // Take the row just written when the read raced the write back
  assign cur = fwd_q ? fwd_data_q : rdata_q;

  always_comb begin
    for (int c = 0; c < pvacc_pkg::NCOMP; c++) begin
      upd[c] = is_tally ? pvacc_pkg::sat_add(cur[c], term[c]) : 64'd0;
    end
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mul_cnt_d   = mul_cnt_q;
    k_d         = k_q;
    wb_valid_d  = 1'b0;
    wb_addr_d   = wb_addr_q;
    fwd_d       = 1'b0;
    fwd_data_d  = fwd_data_q;
    res_d       = res_q;
    clr_d       = clr_q;
    rd_en       = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = wb_addr_q;
    mem_wdata   = upd;
    in_ready_o  = (state_q == S_IDLE);

    // Retire the held result on transfer
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(Depth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          res_d  = '0;
          k_d    = 3'd0;
          if (in_data_i.req_type <= pvacc_pkg::REQ_TALLY4) begin
            mul_cnt_d = 2'd2;
            state_d   = S_MUL;
          end else if (in_data_i.req_type == pvacc_pkg::REQ_READ ||
                       in_data_i.req_type == pvacc_pkg::REQ_READ_CLR) begin
            state_d = S_RMW;
          end
        end
      end
      S_MUL: begin
        mul_cnt_d = mul_cnt_q - 2'd1;
        if (mul_cnt_q == 2'd0) begin
          state_d = S_RMW;
        end
      end
      S_RMW: begin
        // Issue the next atom's row read
        if (k_q < n_atoms) begin
          k_d        = k_q + 3'd1;
          rd_en      = atom_ok;
          wb_valid_d = atom_ok;
          wb_addr_d  = rd_addr;
          fwd_d      = atom_ok && wb_valid_q && (wb_addr_q == rd_addr);
        end
        // Write back the row read in the previous cycle; a plain read only captures it
        if (wb_valid_q) begin
          mem_we     = is_tally || (item_q.req_type == pvacc_pkg::REQ_READ_CLR);
          fwd_data_d = upd;
          if (!is_tally) begin
            res_d = cur;
          end
        end
        if (k_q == n_atoms && !wb_valid_q) begin
          state_d = (is_tally && !item_q.batch_end) ? S_IDLE : S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.result_kind = is_tally ? pvacc_pkg::KIND_DONE : pvacc_pkg::KIND_READ;
          out_d.sum_xx      = is_tally ? 64'd0 : res_q[5];
          out_d.sum_yy      = is_tally ? 64'd0 : res_q[4];
          out_d.sum_zz      = is_tally ? 64'd0 : res_q[3];
          out_d.sum_xy      = is_tally ? 64'd0 : res_q[2];
          out_d.sum_xz      = is_tally ? 64'd0 : res_q[1];
          out_d.sum_yz      = is_tally ? 64'd0 : res_q[0];
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
      mul_cnt_q   <= 2'd0;
      k_q         <= 3'd0;
      wb_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      clr_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      mul_cnt_q   <= mul_cnt_d;
      k_q         <= k_d;
      wb_valid_q  <= wb_valid_d;
      fwd_q       <= fwd_d;
      clr_q       <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    out_q      <= out_d;
    wb_addr_q  <= wb_addr_d;
    fwd_data_q <= fwd_data_d;
    res_q      <= res_d;
  end

  // Row memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/pvacc_checker.sv =====
// ---------------------------------------------------------------------------
// pvacc_checker
// Port-level checks of the per-atom virial accumulator, bound to the top.
// ---------------------------------------------------------------------------
`include "per_atom_virial_accumulator_defines.svh"

module pvacc_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input pvacc_pkg::in_item_t  in_data_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input pvacc_pkg::out_item_t out_data_o
);

  // A result stays offered until its transfer
  `PVACC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")

  // One item in flight: no new transfer right after a tally or read
  `PVACC_ASSERT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_o && (in_data_i.req_type <= pvacc_pkg::REQ_READ_CLR) |=> !in_ready_o, "overlapping items")

  // Done results carry zero sums
  `PVACC_ASSERT_NEVER(a_done_zero, clk_i, rst_ni, out_valid_o && out_data_o.result_kind == pvacc_pkg::KIND_DONE && (out_data_o.sum_xx != 0 || out_data_o.sum_yy != 0 || out_data_o.sum_zz != 0 || out_data_o.sum_xy != 0 || out_data_o.sum_xz != 0 || out_data_o.sum_yz != 0), "done result not zero")

  // A new result only appears while an item is being worked on
  `PVACC_ASSERT(a_result_busy, clk_i, rst_ni, $rose(out_valid_o) |-> $past(!in_ready_o), "result without item")

endmodule

bind per_atom_virial_accumulator pvacc_checker u_pvacc_checker (.*);
